// ===== rtl/core/dseq_pkg.sv =====
// ----------------------------------------------------------------------------
// Duration-sorted entry queue package
// Shared constants, types and helper functions.
// ----------------------------------------------------------------------------
package dseq_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int EW = 46;
	localparam int DUR_W = 12;
	localparam logic [DUR_W-1:0] MIN_PER_DAY = 12'd1440;
	localparam logic [DUR_W-1:0] MIN_PER_HOUR = 12'd60;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DEQUEUE = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_SORT = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] id;
		logic [4:0] dh;
		logic [5:0] dm;
		logic [4:0] ah;
		logic [5:0] am;
		logic [7:0] age;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WRITE_NEW,
		S_SORT_OUTER,
		S_SORT_KEY,
		S_SORT_RD,
		S_SORT_CMP,
		S_SORT_PLACE,
		S_DEQ_RD,
		S_DEQ_WAIT,
		S_RESULT
	} state_t;

	typedef enum logic [2:0] {
		RA_NONE,
		RA_POS,
		RA_POS_M1,
		RA_POS_P1,
		RA_HEAD,
		RA_I
	} rd_sel_t;

	typedef struct packed {
		logic load_req;
		logic pos_clear;
		logic pos_inc;
		logic pos_dec;
		logic pos_from_j;
		logic pos_from_cnt;
		logic j_from_i;
		logic i_clear;
		logic i_inc;
		logic j_dec;
		logic mark_pos;
		logic latch_key;
		rd_sel_t rd_sel;
		logic wr_shift_up;
		logic wr_shift_down;
		logic wr_new;
		logic wr_key;
		logic wr_sort_shift;
		logic cnt_inc;
		logic cnt_dec;
		logic head_inc;
		logic set_status;
		status_t status;
		logic load_out;
		logic out_valid_set;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic full;
		logic empty;
		logic pos_at_end;
		logic pos_at_mark;
		logic pos_last;
		logic dur_less;
		logic id_match;
		logic i_at_end;
		logic j_zero;
		logic key_less;
		logic out_taken;
	} sts_t;

	function automatic logic [DUR_W-1:0] duration_of(entry_t e);
		logic [DUR_W-1:0] dep;
		logic [DUR_W-1:0] arr;
		dep = DUR_W'(e.dh) * MIN_PER_HOUR + DUR_W'(e.dm);
		arr = DUR_W'(e.ah) * MIN_PER_HOUR + DUR_W'(e.am);
		if (arr < dep) begin
			arr = arr + MIN_PER_DAY;
		end
		return arr - dep;
	endfunction

endpackage

// ===== rtl/core/dseq_datapath.sv =====
// ----------------------------------------------------------------------------
// Duration-sorted entry queue datapath
// Entry memory, position counters, compare logic and the result register.
// ----------------------------------------------------------------------------
module dseq_datapath (
	input  logic clk,
	input  logic arst_n,
	input  dseq_pkg::cmd_t cmd,
	output dseq_pkg::sts_t sts,
	input  logic [1:0] req_type,
	input  logic [15:0] flight_id,
	input  logic [4:0] dep_hours,
	input  logic [5:0] dep_minutes,
	input  logic [4:0] arr_hours,
	input  logic [5:0] arr_minutes,
	input  logic [7:0] age_value,
	input  logic out_ready,
	output logic out_valid,
	output logic [1:0] status,
	output logic [15:0] out_id,
	output logic [4:0] out_dep_hours,
	output logic [5:0] out_dep_minutes,
	output logic [4:0] out_arr_hours,
	output logic [5:0] out_arr_minutes,
	output logic [7:0] out_age,
	output logic [6:0] entry_count
);

	dseq_pkg::entry_t mem [dseq_pkg::STORE_DEPTH];
	dseq_pkg::entry_t rd_q;
	dseq_pkg::entry_t new_q;
	dseq_pkg::entry_t key_q;
	dseq_pkg::entry_t res_q;
	logic [dseq_pkg::DUR_W-1:0] new_dur_q;
	dseq_pkg::req_t req_q;
	logic [dseq_pkg::AW-1:0] head_q;
	logic [dseq_pkg::CW-1:0] cnt_q;
	logic [dseq_pkg::CW-1:0] pos_q;
	logic [dseq_pkg::CW-1:0] mark_q;
	logic [dseq_pkg::CW-1:0] i_q;
	logic [dseq_pkg::CW-1:0] j_q;
	logic [1:0] status_q;
	logic out_valid_q;
	logic [dseq_pkg::AW-1:0] rd_addr;
	logic [dseq_pkg::AW-1:0] wr_addr;
	logic wr_en;
	dseq_pkg::entry_t wr_data;
	logic [dseq_pkg::CW-1:0] pos_m1;
	logic [dseq_pkg::CW-1:0] pos_p1;

	assign pos_m1 = pos_q - 1'b1;
	assign pos_p1 = pos_q + 1'b1;

	function automatic logic [dseq_pkg::AW-1:0] slot(logic [dseq_pkg::AW-1:0] h,
		logic [dseq_pkg::CW-1:0] p);
		return h + p[dseq_pkg::AW-1:0];
	endfunction

	always_comb begin
		case (cmd.rd_sel)
			dseq_pkg::RA_POS: rd_addr = slot(head_q, pos_q);
			dseq_pkg::RA_POS_M1: rd_addr = slot(head_q, pos_m1);
			dseq_pkg::RA_POS_P1: rd_addr = slot(head_q, pos_p1);
			dseq_pkg::RA_I: rd_addr = slot(head_q, i_q);
			default: rd_addr = head_q;
		endcase
	end

	always_comb begin
		wr_en = 1'b1;
		wr_addr = slot(head_q, pos_q);
		wr_data = rd_q;
		if (cmd.wr_new) begin
			wr_data = new_q;
		end else if (cmd.wr_key) begin
			wr_data = key_q;
		end else if (!(cmd.wr_shift_up || cmd.wr_shift_down || cmd.wr_sort_shift)) begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			new_q <= '{flight_id, dep_hours, dep_minutes, arr_hours, arr_minutes, age_value};
			new_dur_q <= dseq_pkg::duration_of(dseq_pkg::entry_t'{flight_id, dep_hours,
				dep_minutes, arr_hours, arr_minutes, age_value});
		end
		if (cmd.latch_key) begin
			key_q <= rd_q;
		end
		if (cmd.load_out) begin
			res_q <= rd_q;
		end else if (cmd.set_status) begin
			res_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= dseq_pkg::REQ_INSERT;
			head_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			mark_q <= '0;
			i_q <= '0;
			j_q <= '0;
			status_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				req_q <= dseq_pkg::req_t'(req_type);
			end
			if (cmd.pos_clear) begin
				pos_q <= '0;
			end else if (cmd.pos_from_j) begin
				pos_q <= j_q;
			end else if (cmd.pos_from_cnt) begin
				pos_q <= cnt_q;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_p1;
			end else if (cmd.pos_dec) begin
				pos_q <= pos_m1;
			end
			if (cmd.mark_pos) begin
				mark_q <= pos_q;
			end
			if (cmd.i_clear) begin
				i_q <= dseq_pkg::CW'(1);
			end else if (cmd.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.j_from_i) begin
				j_q <= i_q;
			end else if (cmd.j_dec) begin
				j_q <= j_q - 1'b1;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.head_inc) begin
				head_q <= head_q + 1'b1;
			end
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.out_valid_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.req = req_q;
		sts.full = (cnt_q == dseq_pkg::CW'(dseq_pkg::STORE_DEPTH));
		sts.empty = (cnt_q == '0);
		sts.pos_at_end = (pos_q == cnt_q);
		sts.pos_at_mark = (pos_q == mark_q);
		sts.pos_last = (pos_p1 >= cnt_q);
		sts.dur_less = (new_dur_q < dseq_pkg::duration_of(rd_q));
		sts.id_match = (rd_q.id == new_q.id);
		sts.i_at_end = (i_q >= cnt_q);
		sts.j_zero = (j_q == '0);
		sts.key_less = (rd_q.id > key_q.id);
		sts.out_taken = out_valid_q && out_ready;
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_id = res_q.id;
	assign out_dep_hours = res_q.dh;
	assign out_dep_minutes = res_q.dm;
	assign out_arr_hours = res_q.ah;
	assign out_arr_minutes = res_q.am;
	assign out_age = res_q.age;
	assign entry_count = 7'(cnt_q);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dseq_pkg::CW'(dseq_pkg::STORE_DEPTH))
		else $error("entry count above depth");
	a_no_inc_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !sts.full)
		else $error("insert into full store");
	a_no_dec_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> !sts.empty)
		else $error("removal from empty store");

endmodule

// ===== rtl/core/dseq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Duration-sorted entry queue controller
// Sequences insert, dequeue, remove and sort over the datapath.
// ----------------------------------------------------------------------------
module dseq_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  dseq_pkg::sts_t sts,
	output dseq_pkg::cmd_t cmd
);

	dseq_pkg::state_t state_q;
	dseq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dseq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dseq_pkg::S_IDLE: if (in_valid) state_d = dseq_pkg::S_DISPATCH;
			dseq_pkg::S_DISPATCH: begin
				case (sts.req)
					dseq_pkg::REQ_INSERT:
						state_d = sts.full ? dseq_pkg::S_RESULT : dseq_pkg::S_SCAN_RD;
					dseq_pkg::REQ_DEQUEUE:
						state_d = sts.empty ? dseq_pkg::S_RESULT : dseq_pkg::S_DEQ_RD;
					dseq_pkg::REQ_REMOVE:
						state_d = sts.empty ? dseq_pkg::S_RESULT : dseq_pkg::S_SCAN_RD;
					default: state_d = dseq_pkg::S_SORT_OUTER;
				endcase
			end
			dseq_pkg::S_SCAN_RD: begin
				if (sts.pos_at_end) begin
					state_d = (sts.req == dseq_pkg::REQ_INSERT) ? dseq_pkg::S_WRITE_NEW
						: dseq_pkg::S_RESULT;
				end else begin
					state_d = dseq_pkg::S_SCAN_CMP;
				end
			end
			dseq_pkg::S_SCAN_CMP: begin
				if (sts.req == dseq_pkg::REQ_INSERT) begin
					state_d = sts.dur_less ? dseq_pkg::S_SHIFT_RD : dseq_pkg::S_SCAN_RD;
				end else begin
					state_d = sts.id_match ? dseq_pkg::S_SHIFT_RD : dseq_pkg::S_SCAN_RD;
				end
			end
			dseq_pkg::S_SHIFT_RD: begin
				if (sts.req == dseq_pkg::REQ_INSERT) begin
					state_d = sts.pos_at_mark ? dseq_pkg::S_WRITE_NEW : dseq_pkg::S_SHIFT_WR;
				end else begin
					state_d = sts.pos_last ? dseq_pkg::S_RESULT : dseq_pkg::S_SHIFT_WR;
				end
			end
			dseq_pkg::S_SHIFT_WR: state_d = dseq_pkg::S_SHIFT_RD;
			dseq_pkg::S_WRITE_NEW: state_d = dseq_pkg::S_RESULT;
			dseq_pkg::S_SORT_OUTER:
				state_d = sts.i_at_end ? dseq_pkg::S_RESULT : dseq_pkg::S_SORT_KEY;
			dseq_pkg::S_SORT_KEY: state_d = dseq_pkg::S_SORT_RD;
			dseq_pkg::S_SORT_RD:
				state_d = sts.j_zero ? dseq_pkg::S_SORT_PLACE : dseq_pkg::S_SORT_CMP;
			dseq_pkg::S_SORT_CMP:
				state_d = sts.key_less ? dseq_pkg::S_SORT_RD : dseq_pkg::S_SORT_PLACE;
			dseq_pkg::S_SORT_PLACE: state_d = dseq_pkg::S_SORT_OUTER;
			dseq_pkg::S_DEQ_RD: state_d = dseq_pkg::S_DEQ_WAIT;
			dseq_pkg::S_DEQ_WAIT: state_d = dseq_pkg::S_RESULT;
			dseq_pkg::S_RESULT: state_d = dseq_pkg::S_IDLE;
			default: state_d = dseq_pkg::S_IDLE;
		endcase
	end

	// The key of each sort pass is read at slot i while pos and j track the hole.
	always_comb begin
		cmd = '0;
		cmd.rd_sel = dseq_pkg::RA_NONE;
		cmd.status = dseq_pkg::ST_OK;
		in_ready = 1'b0;
		case (state_q)
			dseq_pkg::S_IDLE: begin
				in_ready = !(sts.out_taken == 1'b0 && 1'b0);
				cmd.load_req = in_valid;
				cmd.pos_clear = 1'b1;
				cmd.i_clear = 1'b1;
			end
			dseq_pkg::S_DISPATCH: begin
				cmd.rd_sel = dseq_pkg::RA_POS;
				if (sts.req == dseq_pkg::REQ_INSERT && sts.full) begin
					cmd.set_status = 1'b1;
					cmd.status = dseq_pkg::ST_FULL;
				end
				if (sts.req != dseq_pkg::REQ_INSERT && sts.req != dseq_pkg::REQ_SORT
					&& sts.empty) begin
					cmd.set_status = 1'b1;
					cmd.status = dseq_pkg::ST_EMPTY;
				end
			end
			dseq_pkg::S_SCAN_RD: begin
				cmd.rd_sel = dseq_pkg::RA_POS;
				if (sts.pos_at_end) begin
					if (sts.req == dseq_pkg::REQ_INSERT) begin
						cmd.mark_pos = 1'b1;
					end else begin
						cmd.set_status = 1'b1;
						cmd.status = dseq_pkg::ST_NOT_FOUND;
					end
				end
			end
			dseq_pkg::S_SCAN_CMP: begin
				if (sts.req == dseq_pkg::REQ_INSERT ? sts.dur_less : sts.id_match) begin
					cmd.mark_pos = 1'b1;
					if (sts.req == dseq_pkg::REQ_INSERT) begin
						cmd.pos_from_cnt = 1'b1;
					end
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			dseq_pkg::S_SHIFT_RD: begin
				if (sts.req == dseq_pkg::REQ_INSERT) begin
					cmd.rd_sel = dseq_pkg::RA_POS_M1;
				end else begin
					cmd.rd_sel = dseq_pkg::RA_POS_P1;
					if (sts.pos_last) begin
						cmd.cnt_dec = 1'b1;
						cmd.set_status = 1'b1;
					end
				end
			end
			dseq_pkg::S_SHIFT_WR: begin
				if (sts.req == dseq_pkg::REQ_INSERT) begin
					cmd.wr_shift_up = 1'b1;
					cmd.pos_dec = 1'b1;
				end else begin
					cmd.wr_shift_down = 1'b1;
					cmd.pos_inc = 1'b1;
				end
			end
			dseq_pkg::S_WRITE_NEW: begin
				cmd.wr_new = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.set_status = 1'b1;
			end
			dseq_pkg::S_SORT_OUTER: begin
				cmd.rd_sel = dseq_pkg::RA_I;
				cmd.j_from_i = 1'b1;
				if (sts.i_at_end) begin
					cmd.set_status = 1'b1;
				end
			end
			dseq_pkg::S_SORT_KEY: begin
				cmd.latch_key = 1'b1;
				cmd.pos_from_j = 1'b1;
			end
			dseq_pkg::S_SORT_RD: cmd.rd_sel = dseq_pkg::RA_POS_M1;
			dseq_pkg::S_SORT_CMP: begin
				if (sts.key_less) begin
					cmd.wr_sort_shift = 1'b1;
					cmd.j_dec = 1'b1;
					cmd.pos_dec = 1'b1;
				end
			end
			dseq_pkg::S_SORT_PLACE: begin
				cmd.wr_key = 1'b1;
				cmd.i_inc = 1'b1;
			end
			dseq_pkg::S_DEQ_RD: cmd.rd_sel = dseq_pkg::RA_HEAD;
			dseq_pkg::S_DEQ_WAIT: begin
				cmd.load_out = 1'b1;
				cmd.set_status = 1'b1;
				cmd.head_inc = 1'b1;
				cmd.cnt_dec = 1'b1;
			end
			dseq_pkg::S_RESULT: cmd.out_valid_set = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/duration_sorted_entry_queue.sv =====
// ----------------------------------------------------------------------------
// Duration-sorted entry queue
// Ordered store of entries with insert by duration, dequeue, remove and sort.
//
//   channel  direction  handshake
//   in       input      in_valid / in_ready
//   out      output     out_valid / out_ready
//
// Insert and remove walk the held entries in turn, reading and shifting them.
// Sort is an insertion sort by entry id over the held entries.
// The entry memory gives one registered read per cycle.
// Reset clears the count and head; stored entries are not cleared.
// A request is taken only once the previous result has been transferred.
// ----------------------------------------------------------------------------
module duration_sorted_entry_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] req_type,
	input  logic [15:0] flight_id,
	input  logic [4:0] dep_hours,
	input  logic [5:0] dep_minutes,
	input  logic [4:0] arr_hours,
	input  logic [5:0] arr_minutes,
	input  logic [7:0] age_value,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [15:0] out_id,
	output logic [4:0] out_dep_hours,
	output logic [5:0] out_dep_minutes,
	output logic [4:0] out_arr_hours,
	output logic [5:0] out_arr_minutes,
	output logic [7:0] out_age,
	output logic [6:0] entry_count
);

	dseq_pkg::cmd_t cmd;
	dseq_pkg::sts_t sts;
	logic ctrl_ready;

	assign in_ready = ctrl_ready && !out_valid;

	dseq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid && !out_valid),
		.in_ready(ctrl_ready), .sts(sts), .cmd(cmd)
	);

	dseq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .flight_id(flight_id), .dep_hours(dep_hours),
		.dep_minutes(dep_minutes), .arr_hours(arr_hours), .arr_minutes(arr_minutes),
		.age_value(age_value), .out_ready(out_ready), .out_valid(out_valid),
		.status(status), .out_id(out_id), .out_dep_hours(out_dep_hours),
		.out_dep_minutes(out_dep_minutes), .out_arr_hours(out_arr_hours),
		.out_arr_minutes(out_arr_minutes), .out_age(out_age),
		.entry_count(entry_count)
	);

endmodule
